### hdl/lyndon_word_generator_defines.svh
// Assertion macros shared by the generator's modules.
`ifndef LYNDON_WORD_GENERATOR_DEFINES_SVH
`define LYNDON_WORD_GENERATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is held.
`define LWG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is held.
`define LWG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`else

`define LWG_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LWG_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/lwg_pkg.sv
package lwg_pkg;

    localparam int MAX_WORD_LEN = 16;
    localparam int MAX_ALPHABET = 16;

    localparam int SYM_W     = $clog2(MAX_ALPHABET);
    localparam int ADDR_W    = $clog2(MAX_WORD_LEN);
    localparam int LEN_W     = $clog2(MAX_WORD_LEN + 1);
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WORD_LENGTH = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] SYMBOL_COUNT_RESET    = CFG_W'(2);
    localparam logic [CFG_W-1:0] MAX_WORD_LENGTH_RESET = CFG_W'(8);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXTEND,
        ST_STRIP,
        ST_EMIT,
        ST_EXHAUST
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_RESTART,
        OP_EXT_INIT,
        OP_EXT_STEP,
        OP_STRIP_INIT,
        OP_STRIP_STEP,
        OP_BUMP,
        OP_SET_DONE,
        OP_EMIT_STEP,
        OP_EXH_LOAD
    } op_t;

    // Store read address: head pointer or tail of the working word.
    typedef enum logic {
        RD_HEAD,
        RD_TAIL
    } rd_sel_t;

    typedef struct packed {
        op_t     op;
        rd_sel_t rd_sel;
    } cmd_t;

    typedef struct packed {
        logic started;
        logic done;
        logic ext_end;
        logic tail_zero;
        logic tail_top;
        logic emit_last;
        logic out_free;
    } status_t;

endpackage

### hdl/lwg_datapath.sv
`include "lyndon_word_generator_defines.svh"

module lwg_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  lwg_pkg::cmd_t              cmd,
    output lwg_pkg::status_t           status,
    input  logic [lwg_pkg::LEN_W-1:0]  eff_len,
    input  logic [lwg_pkg::SYM_W-1:0]  top_sym,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [lwg_pkg::SYM_W-1:0]  m_symbol,
    output logic [lwg_pkg::ADDR_W-1:0] m_position,
    output logic                       m_last_symbol,
    output logic                       m_exhausted
);
    import lwg_pkg::*;

    logic [SYM_W-1:0]  store_reg [MAX_WORD_LEN];
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [SYM_W-1:0]  wr_data;

    logic [LEN_W-1:0]  wl_reg, wl_next;
    logic              started_reg, started_next;
    logic              done_reg, done_next;
    logic [LEN_W-1:0]  i_reg, i_next;
    logic [ADDR_W-1:0] j_reg, j_next;

    logic              m_valid_reg, m_valid_next;
    logic [SYM_W-1:0]  m_symbol_reg, m_symbol_next;
    logic [ADDR_W-1:0] m_position_reg, m_position_next;
    logic              m_last_reg, m_last_next;
    logic              m_exh_reg, m_exh_next;

    logic [LEN_W-1:0]  tail_idx;
    logic [ADDR_W-1:0] rd_addr;
    logic [SYM_W-1:0]  rd_data;
    logic [LEN_W-1:0]  j_plus;
    logic              j_at_end;

    assign tail_idx = i_reg - LEN_W'(1);
    assign rd_addr  = (cmd.rd_sel == RD_TAIL) ? tail_idx[ADDR_W-1:0] : j_reg;
    assign rd_data  = store_reg[rd_addr];
    assign j_plus   = {1'b0, j_reg} + LEN_W'(1);
    assign j_at_end = (j_plus == wl_reg);

    assign status.started   = started_reg;
    assign status.done      = done_reg;
    assign status.ext_end   = (i_reg >= eff_len);
    assign status.tail_zero = (i_reg == '0);
    assign status.tail_top  = (rd_data >= top_sym);
    assign status.emit_last = j_at_end;
    assign status.out_free  = !m_valid_reg || m_ready;

    always_comb begin
        wr_en           = 1'b0;
        wr_addr         = j_reg;
        wr_data         = rd_data;
        wl_next         = wl_reg;
        started_next    = started_reg;
        done_next       = done_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_symbol_next   = m_symbol_reg;
        m_position_next = m_position_reg;
        m_last_next     = m_last_reg;
        m_exh_next      = m_exh_reg;
        case (cmd.op)
            OP_RESTART: begin
                wr_en        = 1'b1;
                wr_addr      = '0;
                wr_data      = '0;
                wl_next      = LEN_W'(1);
                started_next = 1'b1;
                done_next    = 1'b0;
                j_next       = '0;
            end
            OP_EXT_INIT: begin
                i_next = wl_reg;
                j_next = '0;
            end
            OP_EXT_STEP: begin
                // copy the stored word periodically past its end
                wr_en   = 1'b1;
                wr_addr = i_reg[ADDR_W-1:0];
                wr_data = rd_data;
                i_next  = i_reg + LEN_W'(1);
                j_next  = j_at_end ? '0 : j_plus[ADDR_W-1:0];
            end
            OP_STRIP_INIT: begin
                i_next = eff_len;
            end
            OP_STRIP_STEP: begin
                i_next = tail_idx;
            end
            OP_BUMP: begin
                wr_en   = 1'b1;
                wr_addr = tail_idx[ADDR_W-1:0];
                wr_data = rd_data + SYM_W'(1);
                wl_next = i_reg;
                j_next  = '0;
            end
            OP_SET_DONE: begin
                done_next = 1'b1;
            end
            OP_EMIT_STEP: begin
                m_valid_next    = 1'b1;
                m_symbol_next   = rd_data;
                m_position_next = j_reg;
                m_last_next     = j_at_end;
                m_exh_next      = 1'b0;
                j_next          = j_plus[ADDR_W-1:0];
            end
            OP_EXH_LOAD: begin
                m_valid_next    = 1'b1;
                m_symbol_next   = '0;
                m_position_next = '0;
                m_last_next     = 1'b1;
                m_exh_next      = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_reg[wr_addr] <= wr_data;
        end
        m_symbol_reg   <= m_symbol_next;
        m_position_reg <= m_position_next;
        m_last_reg     <= m_last_next;
        m_exh_reg      <= m_exh_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wl_reg      <= '0;
            started_reg <= 1'b0;
            done_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            wl_reg      <= wl_next;
            started_reg <= started_next;
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_symbol      = m_symbol_reg;
    assign m_position    = m_position_reg;
    assign m_last_symbol = m_last_reg;
    assign m_exhausted   = m_exh_reg;

    `LWG_ASSERT_IMPL(a_len_range, aclk, aresetn, started_reg,
        (wl_reg != '0) && (wl_reg <= LEN_W'(MAX_WORD_LEN)))
    `LWG_ASSERT_IMPL(a_exh_form, aclk, aresetn, m_valid_reg && m_exh_reg,
        m_last_reg && (m_symbol_reg == '0) && (m_position_reg == '0))
    `LWG_ASSERT_IMPL(a_bump_below_top, aclk, aresetn, cmd.op == OP_BUMP,
        (rd_data < top_sym) && (i_reg != '0))

endmodule

### hdl/lwg_ctrl.sv
`include "lyndon_word_generator_defines.svh"

module lwg_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_restart,
    input  lwg_pkg::status_t  status,
    output lwg_pkg::cmd_t     cmd
);
    import lwg_pkg::*;

    state_t state_reg, state_next;
    op_t    op;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // read address follows the state alone, so status never loops back into it
    assign cmd.rd_sel = (state_reg == ST_STRIP) ? RD_TAIL : RD_HEAD;
    assign cmd.op     = op;

    always_comb begin
        state_next = state_reg;
        op         = OP_NONE;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_restart || !status.started) begin
                        op         = OP_RESTART;
                        state_next = ST_EMIT;
                    end else if (status.done) begin
                        state_next = ST_EXHAUST;
                    end else begin
                        op         = OP_EXT_INIT;
                        state_next = ST_EXTEND;
                    end
                end
            end
            ST_EXTEND: begin
                if (status.ext_end) begin
                    op         = OP_STRIP_INIT;
                    state_next = ST_STRIP;
                end else begin
                    op = OP_EXT_STEP;
                end
            end
            ST_STRIP: begin
                if (status.tail_zero) begin
                    op         = OP_SET_DONE;
                    state_next = ST_EXHAUST;
                end else if (status.tail_top) begin
                    op = OP_STRIP_STEP;
                end else begin
                    op         = OP_BUMP;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    op = OP_EMIT_STEP;
                    if (status.emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EXHAUST: begin
                if (status.out_free) begin
                    op         = OP_EXH_LOAD;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `LWG_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, (state_reg == ST_IDLE) && s_valid, state_reg != ST_IDLE)

endmodule

### hdl/lyndon_word_generator.sv
// Lyndon word generator: on each input transfer it produces the next Lyndon word, in
// lexicographic order, over the symbols 0 .. (alphabet size - 1) with length up to
// max_word_length, as one output transfer per symbol (position counts from 0,
// last_symbol marks the final one). A transfer with s_restart high, or the first
// after reset, yields the word "0". Once every word is out, each request yields one
// transfer with exhausted and last_symbol high and symbol 0, until a restart.
// Register 0 is the alphabet size (0 acts as 1, above 16 as 16), register 1 is
// max_word_length (0 acts as 1, above 16 as 16); write them only while idle, writes
// to other indexes are dropped. One request is worked at a time. The extend pass,
// the strip scan and the symbol output share the single read port of the word
// store, one entry per cycle, and the symbol output waits while the output side stalls.
module lyndon_word_generator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lwg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lwg_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_restart,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lwg_pkg::SYM_W-1:0]     m_symbol,
    output logic [lwg_pkg::ADDR_W-1:0]    m_position,
    output logic                          m_last_symbol,
    output logic                          m_exhausted
);
    import lwg_pkg::*;

    logic [CFG_W-1:0] alpha_reg, alpha_next;
    logic [CFG_W-1:0] max_len_reg, max_len_next;
    logic [CFG_W-1:0] eff_alpha;
    logic [LEN_W-1:0] eff_len;
    logic [SYM_W-1:0] top_sym;

    cmd_t    cmd;
    status_t status;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_comb begin
        alpha_next   = alpha_reg;
        max_len_next = max_len_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_SYMBOL_COUNT:    alpha_next   = cfg_data;
                REG_MAX_WORD_LENGTH: max_len_next = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg   <= SYMBOL_COUNT_RESET;
            max_len_reg <= MAX_WORD_LENGTH_RESET;
        end else begin
            alpha_reg   <= alpha_next;
            max_len_reg <= max_len_next;
        end
    end

    // Clamp both registers into their legal ranges; the top symbol is one below
    // the alphabet size, and anything at or above it is stripped.
    always_comb begin
        if (alpha_reg == '0) begin
            eff_alpha = CFG_W'(1);
        end else if (alpha_reg > CFG_W'(MAX_ALPHABET)) begin
            eff_alpha = CFG_W'(MAX_ALPHABET);
        end else begin
            eff_alpha = alpha_reg;
        end
        if (max_len_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (max_len_reg > CFG_W'(MAX_WORD_LEN)) begin
            eff_len = LEN_W'(MAX_WORD_LEN);
        end else begin
            eff_len = LEN_W'(max_len_reg);
        end
    end

    assign top_sym = SYM_W'(eff_alpha - CFG_W'(1));

    lwg_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_restart (s_restart),
        .status    (status),
        .cmd       (cmd)
    );

    // Word store, working counters and the output register.
    lwg_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .eff_len       (eff_len),
        .top_sym       (top_sym),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_symbol      (m_symbol),
        .m_position    (m_position),
        .m_last_symbol (m_last_symbol),
        .m_exhausted   (m_exhausted)
    );

endmodule

### bench/tb_lyndon_word_generator.sv
module tb_lyndon_word_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import lwg_pkg::*;

    // Indexes past the end of the register list: the block must drop them.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = CFG_IDX_W'(3);

    localparam int REQUEST_TARGET = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 300;
    localparam int SQUEEZE_PHASE  = 3;
    localparam int DRAIN_CYCLES   = 60;

    // One output transfer: a symbol of the word, or the exhausted marker.
    typedef struct packed {
        logic [SYM_W-1:0]  symbol;
        logic [ADDR_W-1:0] position;
        logic              last_symbol;
        logic              exhausted;
    } symbol_beat_t;

    typedef enum logic {ROW_WRITE_REG, ROW_REQUEST} row_kind_t;
    typedef enum logic [1:0] {GOLD_NONE, GOLD_WORD, GOLD_EXHAUSTED} golden_t;
    typedef enum logic [1:0] {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;
    typedef enum logic [1:0] {PH_EXHAUST, PH_MIDDLE, PH_SWEEP, PH_ANY} phase_flavour_t;

    // A stimulus row: either a register write or a request. Requests with a golden
    // word carry their answer here; the rest are left to the predictor.
    typedef struct packed {
        row_kind_t                          kind;
        logic [CFG_IDX_W-1:0]               reg_index;
        logic [CFG_W-1:0]                   reg_value;
        logic                               restart;
        golden_t                            golden;
        logic [LEN_W-1:0]                   golden_len;
        logic [MAX_WORD_LEN-1:0][SYM_W-1:0] golden_word;
    } stim_row_t;

    // Directed part. Symbol i of a golden word sits in nibble i.
    localparam stim_row_t DIRECTED [34] = '{
        // request before any restart behaves as a restart
        '{ROW_REQUEST, '0, '0, 1'b0, GOLD_WORD, 5'd1, 64'h0},
        '{ROW_REQUEST, '0, '0, 1'b1, GOLD_WORD, 5'd1, 64'h0},
        // reset settings: "0" repeated to eight symbols, last one bumped
        '{ROW_REQUEST, '0, '0, 1'b0, GOLD_WORD, 5'd8, 64'h0000_0000_1000_0000},
        '{ROW_REQUEST, '0, '0, 1'b0, GOLD_NONE, 5'd0, 64'h0},
        // single-symbol alphabet: everything strips away at once
        '{ROW_WRITE_REG, REG_SYMBOL_COUNT, 5'd1, 1'b0, GOLD_NONE, 5'd0, 64'h0},
        '{ROW_REQUEST, '0, '0, 1'b0, GOLD_EXHAUSTED, 5'd0, 64'h0},
        '{ROW_REQUEST, '0, '0, 1'b0, GOLD_EXHAUSTED, 5'd0, 64'h0},
        '{ROW_REQUEST, '0, '0, 1'b1, GOLD_WORD, 5'd1, 64'h0},
        // alphabet size zero acts as one
        '{ROW_WRITE_REG, REG_SYMBOL_COUNT, 5'd0, 1'b0, GOLD_NONE, 5'd0, 64'h0},
        '{ROW_REQUEST, '0, '0, 1'b0, GOLD_EXHAUSTED, 5'd0, 64'h0},
        // alphabet size beyond the top saturates, length one
        '{ROW_WRITE_REG, REG_SYMBOL_COUNT, 5'd31, 1'b0, GOLD_NONE, 5'd0, 64'h0},
        '{ROW_WRITE_REG, REG_MAX_WORD_LENGTH, 5'd1, 1'b0, GOLD_NONE, 5'd0, 64'h0},
        '{ROW_REQUEST, '0, '0, 1'b1, GOLD_WORD, 5'd1, 64'h0},
        '{ROW_REQUEST, '0, '0, 1'b0, GOLD_WORD, 5'd1, 64'h1},
        '{ROW_REQUEST, '0, '0, 1'b0, GOLD_NONE, 5'd0, 64'h0},
        // length zero acts as one
        '{ROW_WRITE_REG, REG_MAX_WORD_LENGTH, 5'd0, 1'b0, GOLD_NONE, 5'd0, 64'h0},
        '{ROW_REQUEST, '0, '0, 1'b0, GOLD_NONE, 5'd0, 64'h0},
        // length beyond the top saturates at sixteen
        '{ROW_WRITE_REG, REG_MAX_WORD_LENGTH, 5'd31, 1'b0, GOLD_NONE, 5'd0, 64'h0},
        '{ROW_REQUEST, '0, '0, 1'b0, GOLD_NONE, 5'd0, 64'h0},
        // shrink the alphabet under a stored word holding large symbols
        '{ROW_WRITE_REG, REG_SYMBOL_COUNT, 5'd2, 1'b0, GOLD_NONE, 5'd0, 64'h0},
        '{ROW_REQUEST, '0, '0, 1'b0, GOLD_NONE, 5'd0, 64'h0},
        // writes past the register list are dropped
        '{ROW_WRITE_REG, REG_UNUSED_LO, 5'd31, 1'b0, GOLD_NONE, 5'd0, 64'h0},
        '{ROW_WRITE_REG, REG_UNUSED_HI, 5'd0, 1'b0, GOLD_NONE, 5'd0, 64'h0},
        '{ROW_REQUEST, '0, '0, 1'b1, GOLD_WORD, 5'd1, 64'h0},
        // full-length word: fifteen zeros then a one
        '{ROW_REQUEST, '0, '0, 1'b0, GOLD_WORD, 5'd16, 64'h1000_0000_0000_0000},
        // walk to "003", then narrow the alphabet so the 3, now above the top symbol, is stripped
        '{ROW_WRITE_REG, REG_SYMBOL_COUNT, 5'd4, 1'b0, GOLD_NONE, 5'd0, 64'h0},
        '{ROW_WRITE_REG, REG_MAX_WORD_LENGTH, 5'd3, 1'b0, GOLD_NONE, 5'd0, 64'h0},
        '{ROW_REQUEST, '0, '0, 1'b1, GOLD_NONE, 5'd0, 64'h0},
        '{ROW_REQUEST, '0, '0, 1'b0, GOLD_NONE, 5'd0, 64'h0},
        '{ROW_REQUEST, '0, '0, 1'b0, GOLD_NONE, 5'd0, 64'h0},
        '{ROW_REQUEST, '0, '0, 1'b0, GOLD_NONE, 5'd0, 64'h0},
        '{ROW_WRITE_REG, REG_SYMBOL_COUNT, 5'd3, 1'b0, GOLD_NONE, 5'd0, 64'h0},
        '{ROW_REQUEST, '0, '0, 1'b0, GOLD_NONE, 5'd0, 64'h0},
        '{ROW_REQUEST, '0, '0, 1'b0, GOLD_NONE, 5'd0, 64'h0}
    };

    // Every input starts at a known value.
    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]     cfg_data      = '0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic                 s_restart     = 1'b0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [SYM_W-1:0]     m_symbol;
    logic [ADDR_W-1:0]    m_position;
    logic                 m_last_symbol;
    logic                 m_exhausted;

    lyndon_word_generator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_restart     (s_restart),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_symbol      (m_symbol),
        .m_position    (m_position),
        .m_last_symbol (m_last_symbol),
        .m_exhausted   (m_exhausted)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Shadow of the generator: its settings, the previous word and the
    // sequence flags, advanced once per accepted request.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] alphabet_setting = SYMBOL_COUNT_RESET;
    logic [CFG_W-1:0] length_setting   = MAX_WORD_LENGTH_RESET;
    logic [SYM_W-1:0] prev_word [MAX_WORD_LEN] = '{default: '0};
    int unsigned      prev_len     = 0;
    bit               seq_started  = 1'b0;
    bit               seq_finished = 1'b0;

    symbol_beat_t fresh_word [$];     // transfers of the word just worked out
    symbol_beat_t awaited_beats [$];  // transfers still owed by the block

    int unsigned mismatches    = 0;
    int unsigned requests_sent = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned burst_left    = 0;
    bit          gapless       = 1'b0;
    stim_row_t   offer_row     = '0;

    function automatic int unsigned clamp_setting(input logic [CFG_W-1:0] value,
                                                  input int unsigned ceiling);
        if (value == 0)
            return 1;
        if (value > ceiling)
            return ceiling;
        return value;
    endfunction

    function automatic void queue_beat(input int unsigned sym, input int unsigned pos,
                                       input bit last, input bit exh);
        symbol_beat_t b;
        b = '{SYM_W'(sym), ADDR_W'(pos), last, exh};
        fresh_word.insert(fresh_word.size(), b);
    endfunction

    // Duval step: repeat the previous word out to the length limit, drop trailing
    // top symbols (or anything above them), bump the final symbol.
    function automatic void advance_lyndon_word(input logic restart_req);
        logic [SYM_W-1:0] stretched [MAX_WORD_LEN];
        int unsigned      span;
        int unsigned      top;
        int unsigned      keep;
        fresh_word.delete();
        if (restart_req || !seq_started || prev_len == 0) begin
            prev_word[0] = '0;
            prev_len     = 1;
            seq_started  = 1'b1;
            seq_finished = 1'b0;
            queue_beat(0, 0, 1'b1, 1'b0);
            return;
        end
        if (seq_finished) begin
            queue_beat(0, 0, 1'b1, 1'b1);
            return;
        end
        span = clamp_setting(length_setting, MAX_WORD_LEN);
        top  = clamp_setting(alphabet_setting, MAX_ALPHABET) - 1;
        for (int i = 0; i < span; i++)
            stretched[i] = prev_word[i % prev_len];
        keep = span;
        while (keep > 0 && stretched[keep-1] >= top)
            keep--;
        if (keep == 0) begin
            seq_finished = 1'b1;
            queue_beat(0, 0, 1'b1, 1'b1);
            return;
        end
        stretched[keep-1] = stretched[keep-1] + 1'b1;
        for (int i = 0; i < keep; i++) begin
            prev_word[i] = stretched[i];
            queue_beat(stretched[i], i, i + 1 == keep, 1'b0);
        end
        prev_len = keep;
    endfunction

    // ------------------------------------------------------------------
    // Monitor and scoreboard: sample every channel at the edge, mirror
    // register writes, predict on each request transfer and check each
    // result transfer against the oldest owed one.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        symbol_beat_t beat;
        if (aresetn && cfg_valid && cfg_ready) begin
            if (cfg_index == REG_SYMBOL_COUNT)
                alphabet_setting = cfg_data;
            else if (cfg_index == REG_MAX_WORD_LENGTH)
                length_setting = cfg_data;
        end
        if (aresetn && s_valid && s_ready) begin
            advance_lyndon_word(s_restart);
            case (offer_row.golden)
                GOLD_WORD: begin
                    for (int i = 0; i < offer_row.golden_len; i++) begin
                        beat = '{offer_row.golden_word[i], ADDR_W'(i),
                                 i + 1 == offer_row.golden_len, 1'b0};
                        awaited_beats.insert(awaited_beats.size(), beat);
                    end
                end
                GOLD_EXHAUSTED: begin
                    beat = '{'0, '0, 1'b1, 1'b1};
                    awaited_beats.insert(awaited_beats.size(), beat);
                end
                default: begin
                    foreach (fresh_word[i])
                        awaited_beats.insert(awaited_beats.size(), fresh_word[i]);
                end
            endcase
        end
        if (aresetn && m_valid && m_ready) begin
            if (awaited_beats.size() == 0) begin
                $error("result transfer with nothing owed: m_symbol %0d m_position %0d",
                       m_symbol, m_position);
                mismatches++;
            end else begin
                beat = awaited_beats.pop_front();
                if (m_symbol !== beat.symbol) begin
                    $error("m_symbol: expected %0d, actual %0d", beat.symbol, m_symbol);
                    mismatches++;
                end
                if (m_position !== beat.position) begin
                    $error("m_position: expected %0d, actual %0d", beat.position, m_position);
                    mismatches++;
                end
                if (m_last_symbol !== beat.last_symbol) begin
                    $error("m_last_symbol: expected %0d, actual %0d",
                           beat.last_symbol, m_last_symbol);
                    mismatches++;
                end
                if (m_exhausted !== beat.exhausted) begin
                    $error("m_exhausted: expected %0d, actual %0d", beat.exhausted, m_exhausted);
                    mismatches++;
                end
            end
        end
    end

    // Count cycles in which no request or register transfer happens.
    always @(posedge aclk) begin
        if ((cfg_valid && cfg_ready) || (s_valid && s_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("lyndon_word_generator verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: stall on a pattern of its own, switching to a random mode when
    // its mode count runs out. Once, on request from the stimulus, hold
    // off for a long stretch so the block backs up into its input.
    // ------------------------------------------------------------------
    rx_mode_t    rx_mode      = RX_ALWAYS;
    int unsigned mode_left    = 0;
    int unsigned hold_left    = 0;
    logic        squeeze_req  = 1'b0;
    logic        squeeze_done = 1'b0;

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (squeeze_req && !squeeze_done) begin
            squeeze_done <= 1'b1;
            hold_left    <= LONG_HOLD;
            m_ready      <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   <= rx_mode_t'($urandom_range(0, 3));
                mode_left <= $urandom_range(16, 96);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_ALWAYS: m_ready <= 1'b1;
                RX_HALF:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:   m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------

    // Offer one request and hold it until the transfer. Valid stays high
    // into the next call unless a gap is due, so bursts run back to back.
    task automatic offer_request(input stim_row_t row);
        int unsigned gap;
        cfg_valid <= 1'b0;
        if (burst_left == 0) begin
            gap = gapless ? 0 : $urandom_range(0, 7);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_valid   <= 1'b1;
        s_restart <= row.restart;
        offer_row <= row;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        requests_sent++;
    endtask

    // Write one register. Coming from requests, drop valid and wait until
    // every owed transfer is in so the block is idle; back-to-back writes
    // keep cfg_valid high and just change the payload.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_W-1:0] value);
        if (cfg_valid == 1'b0) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while (awaited_beats.size() != 0) @(posedge aclk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    initial begin
        stim_row_t            row;
        phase_flavour_t       flavour;
        logic [CFG_W-1:0]     alpha_pick;
        logic [CFG_W-1:0]     length_pick;
        int unsigned          phase_items;
        int unsigned          phase_count;

        phase_count = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table first.
        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].kind == ROW_WRITE_REG)
                write_register(DIRECTED[r].reg_index, DIRECTED[r].reg_value);
            else
                offer_request(DIRECTED[r]);
        end

        // Random phases: each picks settings, then runs a stretch of mostly
        // "next word" requests with the odd restart thrown in. Small settings
        // run to exhaustion; sweeps push single symbols up to the top.
        while (requests_sent < REQUEST_TARGET) begin
            phase_count++;
            if (phase_count % 4 == 2)
                flavour = PH_SWEEP;
            else
                flavour = phase_flavour_t'($urandom_range(0, 3));
            case (flavour)
                PH_EXHAUST: begin
                    alpha_pick  = CFG_W'($urandom_range(1, 4));
                    length_pick = CFG_W'($urandom_range(1, 5));
                end
                PH_MIDDLE: begin
                    alpha_pick  = CFG_W'($urandom_range(2, 6));
                    length_pick = CFG_W'($urandom_range(2, 8));
                end
                PH_SWEEP: begin
                    alpha_pick  = CFG_W'($urandom_range(16, 31));
                    length_pick = CFG_W'($urandom_range(1, 2));
                end
                default: begin
                    alpha_pick  = CFG_W'($urandom_range(0, 31));
                    length_pick = CFG_W'($urandom_range(0, 31));
                end
            endcase
            // Skip a write now and then so settings change under a live sequence.
            if (flavour == PH_SWEEP || $urandom_range(0, 3) != 0)
                write_register(REG_SYMBOL_COUNT, alpha_pick);
            if (flavour == PH_SWEEP || $urandom_range(0, 3) != 0)
                write_register(REG_MAX_WORD_LENGTH, length_pick);
            if ($urandom_range(0, 7) == 0)
                write_register($urandom_range(0, 1) ? REG_UNUSED_HI : REG_UNUSED_LO,
                               CFG_W'($urandom_range(0, 31)));

            gapless = (phase_count == SQUEEZE_PHASE) || ($urandom_range(0, 3) == 0);
            if (phase_count == SQUEEZE_PHASE)
                squeeze_req <= 1'b1;

            phase_items = (flavour == PH_SWEEP) ? 40 : $urandom_range(8, 40);
            for (int k = 0; k < phase_items; k++) begin
                row         = '0;
                row.kind    = ROW_REQUEST;
                row.golden  = GOLD_NONE;
                if (k == 0)
                    row.restart = (flavour == PH_SWEEP) || ($urandom_range(0, 1) == 1);
                else
                    row.restart = ($urandom_range(0, 29) == 0);
                offer_request(row);
            end
        end

        // Drain: stop offering, wait for every owed transfer, then watch a
        // little longer for anything spurious.
        s_valid   <= 1'b0;
        cfg_valid <= 1'b0;
        @(posedge aclk);
        while (awaited_beats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && awaited_beats.size() == 0)
            $display("lyndon_word_generator verification clean");
        else
            $display("lyndon_word_generator verification failed");
        $finish;
    end

endmodule
